// File: rtl/dadsr_pkg.sv
package dadsr_pkg;

   // Field and datapath widths.
   localparam int TIME_W      = 32;
   localparam int TICK_W      = 24;
   localparam int WEIGHT_W    = 16;
   localparam int SPAN_W      = TICK_W + 2;
   localparam int PROD_W      = TIME_W + WEIGHT_W;
   localparam int REM_W       = TICK_W + 1;
   localparam int DIV_STEPS   = PROD_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   // Unity weight in Q1.15.
   localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(32768);

   // Register reset values.
   localparam logic [TICK_W-1:0]   DELAY_RST   = TICK_W'(0);
   localparam logic [TICK_W-1:0]   ATTACK_RST  = TICK_W'(480);
   localparam logic [TICK_W-1:0]   DECAY_RST   = TICK_W'(4800);
   localparam logic [WEIGHT_W-1:0] SUSTAIN_RST = WEIGHT_W'(24576);
   localparam logic [TICK_W-1:0]   RELEASE_RST = TICK_W'(4800);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY   = 3'd0,
      CSR_ATTACK  = 3'd1,
      CSR_DECAY   = 3'd2,
      CSR_SUSTAIN = 3'd3,
      CSR_RELEASE = 3'd4
   } csr_index_type;

   // Envelope stage codes as reported on the result channel.
   typedef enum logic [2:0] {
      STAGE_OFF     = 3'd0,
      STAGE_DELAY   = 3'd1,
      STAGE_ATTACK  = 3'd2,
      STAGE_DECAY   = 3'd3,
      STAGE_SUSTAIN = 3'd4,
      STAGE_RELEASE = 3'd5
   } stage_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic classify;
      logic mul;
      logic div_step;
      logic finish;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic out_free;
   } ctl_status_type;

endpackage

// File: rtl/dadsr_ctrl.sv
module dadsr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  dadsr_pkg::ctl_status_type status,
   output dadsr_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASSIFY,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [dadsr_pkg::CNT_W-1:0]  count_ff, count_in;

   // Next state and step counter for the serial divider.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            count_in = '0;
            state_in = status.need_div ? S_DIV : S_FINISH;
         end
         S_DIV: begin
            if (count_ff == dadsr_pkg::CNT_W'(dadsr_pkg::DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Command decode.
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      cmd.load     = (state_ff == S_IDLE) && req_tvalid;
      cmd.classify = (state_ff == S_CLASSIFY);
      cmd.mul      = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_FINISH) && status.out_free;
   end

endmodule

// File: rtl/dadsr_datapath.sv
module dadsr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [dadsr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dadsr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [dadsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dadsr_pkg::TICK_W-1:0]         csr_wdata,
   input  dadsr_pkg::ctl_cmd_type               cmd,
   output dadsr_pkg::ctl_status_type            status
);

   localparam int TW = dadsr_pkg::TIME_W;
   localparam int KW = dadsr_pkg::TICK_W;
   localparam int WW = dadsr_pkg::WEIGHT_W;
   localparam int SW = dadsr_pkg::SPAN_W;
   localparam int PW = dadsr_pkg::PROD_W;
   localparam int RW = dadsr_pkg::REM_W;

   // Configuration registers.
   logic [KW-1:0] delay_ff, attack_ff, decay_ff, release_ff;
   logic [WW-1:0] sustain_ff;

   // Voice state.
   logic          key_down_ff, voice_on_ff, releasing_ff;
   logic [TW-1:0] last_time_ff;
   logic [WW-1:0] last_weight_ff;

   // Current request.
   logic          key_ff, pedal_ff;
   logic [TW-1:0] time_ff;

   // Per-request working registers.
   dadsr_pkg::stage_type stage_ff;
   logic [TW-1:0] op_a_ff;
   logic [WW-1:0] op_b_ff;
   logic [KW-1:0] divisor_ff;
   logic          need_div_ff, rel_back_ff;
   logic [PW-1:0] dq_ff;
   logic [RW-1:0] rem_ff;

   // Result register.
   logic          rsp_valid_ff;
   logic [WW-1:0] rsp_weight_ff;
   logic          rsp_sounding_ff;
   dadsr_pkg::stage_type rsp_stage_ff;

   // Classification of the current request.
   logic          vo_new, rl_new, key_rise;
   logic [WW-1:0] sus;
   logic [SW-1:0] d1, d2;
   dadsr_pkg::stage_type stage_in;
   logic [TW-1:0] op_a_in;
   logic [WW-1:0] op_b_in;
   logic [KW-1:0] divisor_in;
   logic          back;

   always_comb begin
      key_rise = key_ff && !key_down_ff;
      vo_new   = key_rise | voice_on_ff;
      rl_new   = key_rise ? 1'b0 : releasing_ff;
      sus      = (sustain_ff > dadsr_pkg::W_ONE) ? dadsr_pkg::W_ONE : sustain_ff;
      d1       = SW'(delay_ff) + SW'(attack_ff);
      d2       = d1 + SW'(decay_ff);
      back     = time_ff < last_time_ff;

      if (!vo_new) begin
         stage_in = dadsr_pkg::STAGE_OFF;
      end else if (key_ff && time_ff < TW'(delay_ff)) begin
         stage_in = dadsr_pkg::STAGE_DELAY;
      end else if (key_ff && time_ff < TW'(d1)) begin
         stage_in = dadsr_pkg::STAGE_ATTACK;
      end else if (key_ff && time_ff < TW'(d2)) begin
         stage_in = dadsr_pkg::STAGE_DECAY;
      end else if (key_ff || (pedal_ff && !rl_new)) begin
         stage_in = dadsr_pkg::STAGE_SUSTAIN;
      end else begin
         stage_in = dadsr_pkg::STAGE_RELEASE;
      end

      op_a_in    = '0;
      op_b_in    = '0;
      divisor_in = release_ff;
      case (stage_in)
         dadsr_pkg::STAGE_ATTACK: begin
            op_a_in    = time_ff - TW'(delay_ff);
            op_b_in    = dadsr_pkg::W_ONE;
            divisor_in = attack_ff;
         end
         dadsr_pkg::STAGE_DECAY: begin
            op_a_in    = time_ff - TW'(d1);
            op_b_in    = dadsr_pkg::W_ONE - sus;
            divisor_in = decay_ff;
         end
         dadsr_pkg::STAGE_RELEASE: begin
            op_a_in    = back ? (last_time_ff - time_ff) : (time_ff - last_time_ff);
            op_b_in    = last_weight_ff;
            divisor_in = release_ff;
         end
         default: begin
            op_a_in = '0;
         end
      endcase
   end

   // One restoring division step: a quotient bit enters at the bottom.
   logic [RW-1:0] rem_shift, rem_diff;
   logic          q_bit;

   always_comb begin
      rem_shift = {rem_ff[RW-2:0], dq_ff[PW-1]};
      rem_diff  = rem_shift - RW'(divisor_ff);
      q_bit     = rem_shift >= RW'(divisor_ff);
   end

   // Final weight from the quotient.
   logic [WW-1:0] w_out;
   logic [WW+1:0] back_sum;
   logic          rel_past, sounding_out;

   always_comb begin
      back_sum = (WW+2)'(last_weight_ff) + (WW+2)'(dq_ff[WW:0]);
      rel_past = op_a_ff >= TW'(release_ff);
      case (stage_ff)
         dadsr_pkg::STAGE_ATTACK: begin
            w_out = dq_ff[WW-1:0];
         end
         dadsr_pkg::STAGE_DECAY: begin
            w_out = dadsr_pkg::W_ONE - dq_ff[WW-1:0];
         end
         dadsr_pkg::STAGE_SUSTAIN: begin
            w_out = sus;
         end
         dadsr_pkg::STAGE_RELEASE: begin
            if (release_ff == '0) begin
               w_out = last_weight_ff >> 1;
            end else if (!rel_back_ff) begin
               w_out = rel_past ? '0 : (last_weight_ff - dq_ff[WW-1:0]);
            end else if ((|dq_ff[PW-1:WW+1]) ||
                         (back_sum > (WW+2)'(dadsr_pkg::W_ONE))) begin
               w_out = dadsr_pkg::W_ONE;
            end else begin
               w_out = back_sum[WW-1:0];
            end
         end
         default: begin
            w_out = '0;
         end
      endcase
      if (stage_ff == dadsr_pkg::STAGE_RELEASE) begin
         sounding_out = (w_out != '0);
      end else begin
         sounding_out = voice_on_ff;
      end
   end

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= dadsr_pkg::DELAY_RST;
         attack_ff  <= dadsr_pkg::ATTACK_RST;
         decay_ff   <= dadsr_pkg::DECAY_RST;
         sustain_ff <= dadsr_pkg::SUSTAIN_RST;
         release_ff <= dadsr_pkg::RELEASE_RST;
      end else if (csr_we) begin
         case (csr_index)
            dadsr_pkg::CSR_DELAY:   delay_ff   <= csr_wdata;
            dadsr_pkg::CSR_ATTACK:  attack_ff  <= csr_wdata;
            dadsr_pkg::CSR_DECAY:   decay_ff   <= csr_wdata;
            dadsr_pkg::CSR_SUSTAIN: sustain_ff <= csr_wdata[WW-1:0];
            dadsr_pkg::CSR_RELEASE: release_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Voice state updates at classification and at the end of a request.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_down_ff    <= 1'b0;
         voice_on_ff    <= 1'b0;
         releasing_ff   <= 1'b0;
         last_time_ff   <= '0;
         last_weight_ff <= '0;
      end else if (cmd.classify) begin
         key_down_ff  <= key_ff;
         voice_on_ff  <= vo_new;
         releasing_ff <= rl_new | (stage_in == dadsr_pkg::STAGE_RELEASE);
      end else if (cmd.finish) begin
         if (stage_ff == dadsr_pkg::STAGE_RELEASE) begin
            voice_on_ff <= sounding_out;
         end else begin
            last_time_ff   <= time_ff;
            last_weight_ff <= w_out;
         end
      end
   end

   // Request capture, operand setup, multiply and divide.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_tdata[0];
         pedal_ff <= req_tdata[1];
         time_ff  <= req_tdata[TW+1:2];
      end
      if (cmd.classify) begin
         stage_ff    <= stage_in;
         op_a_ff     <= op_a_in;
         op_b_ff     <= op_b_in;
         divisor_ff  <= divisor_in;
         rel_back_ff <= back;
         need_div_ff <= (stage_in == dadsr_pkg::STAGE_ATTACK) ||
                        (stage_in == dadsr_pkg::STAGE_DECAY) ||
                        ((stage_in == dadsr_pkg::STAGE_RELEASE) && (release_ff != '0));
      end
      if (cmd.mul) begin
         dq_ff  <= PW'(op_a_ff) * PW'(op_b_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[PW-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff : rem_shift;
      end
   end

   // Result register; it holds until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_weight_ff   <= w_out;
         rsp_sounding_ff <= sounding_out;
         rsp_stage_ff    <= stage_ff;
      end
   end

   always_comb begin
      status.need_div = need_div_ff;
      status.out_free = !rsp_valid_ff || rsp_tready;
      rsp_tvalid      = rsp_valid_ff;
      rsp_tdata       = {4'b0, rsp_stage_ff, rsp_sounding_ff, rsp_weight_ff};
   end

endmodule

// File: rtl/dadsr_envelope_with_pedal.sv
// DADSR envelope for one voice with a sustain pedal. Each request carries the
// key level, the pedal level and the note time; each request gives exactly one
// result with the Q1.15 weight, the sounding flag and the stage. One request is
// worked on at a time. A request in the attack, decay or release stage (with a
// nonzero release span) goes through acceptance, classification, the 32x16
// multiply, the one-bit-per-cycle restoring divider and the load of the result
// register; then the next request can be accepted. The divider sets the rate.
// All other requests skip the divider. A finished result waits in an output
// register, so the next request is taken while the previous result is still
// pending; only a result that is still unread when the next one finishes holds
// the block back. The user must write registers through the csr port only
// while the block is idle; the block itself does not enforce this.
module dadsr_envelope_with_pedal (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Bits from 0 up: key_held, pedal_held, note_time[31:0], zero fill.
   input  logic [dadsr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Bits from 0 up: weight[15:0], sounding, stage[2:0], zero fill.
   output logic [dadsr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [dadsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dadsr_pkg::TICK_W-1:0]         csr_wdata
);

   dadsr_pkg::ctl_cmd_type    cmd;
   dadsr_pkg::ctl_status_type status;

   // Sequencer.
   dadsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Envelope arithmetic, voice state and registers.
   dadsr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
